// ===== hw/rtl/pma_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the polynomial block.
package pma_pkg;

  localparam int MAX_EXP    = 1023;
  localparam int SRC_DEPTH  = MAX_EXP + 1;
  localparam int PROD_DEPTH = 2 * MAX_EXP + 1;
  localparam int EXP_W      = 10;
  localparam int PEXP_W     = 11;
  localparam int COEF_W     = 16;
  localparam int MUL_W      = 2 * COEF_W;
  localparam int ACC_W      = 48;
  localparam int ACTION_W   = 3;
  localparam int PHASE_W    = 2;

  // Item action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_COMPUTE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_EMIT    = 3'd4;

  // Emission phases
  localparam logic [PHASE_W-1:0] PH_PROD = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SUM  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PCLR,
    ST_A_RD,
    ST_A_CHK,
    ST_B_RD,
    ST_B_CHK,
    ST_B_WR,
    ST_E_RD,
    ST_E_CHK,
    ST_E_OUT
  } state_t;

  typedef struct packed {
    logic clr_all;
    logic clr_prod;
    logic cur_init;
    logic restart;
    logic load_a;
    logic load_b;
    logic i_init;
    logic i_inc;
    logic j_init;
    logic j_inc;
    logic a_rd;
    logic b_rd;
    logic mul;
    logic p_wr;
    logic emit_init;
    logic e_rd;
    logic e_chk;
    logic e_out;
  } cmd_t;

  typedef struct packed {
    logic cur_last;
    logic a_zero;
    logic b_zero;
    logic i_last;
    logic j_last;
    logic phase_done;
    logic go_out;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/pma_ctrl.sv =====
// Controller state machine: sequences clear sweeps, the product loop and the emit scan.
module pma_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [pma_pkg::ACTION_W-1:0]  in_action,
  input  pma_pkg::sts_t                 sts_i,
  output pma_pkg::cmd_t                 cmd_o,
  output logic                          in_stall
);

  pma_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign in_stall = (state_r != pma_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pma_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pma_pkg::ST_CLR: begin
        if (sts_i.cur_last) state_nxt = pma_pkg::ST_IDLE;
      end
      pma_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            pma_pkg::ACT_CLEAR:   state_nxt = pma_pkg::ST_CLR;
            pma_pkg::ACT_COMPUTE: state_nxt = pma_pkg::ST_PCLR;
            pma_pkg::ACT_EMIT: begin
              if (!sts_i.phase_done) state_nxt = pma_pkg::ST_E_RD;
            end
            default: state_nxt = pma_pkg::ST_IDLE;
          endcase
        end
      end
      pma_pkg::ST_PCLR: begin
        if (sts_i.cur_last) state_nxt = pma_pkg::ST_A_RD;
      end
      pma_pkg::ST_A_RD:  state_nxt = pma_pkg::ST_A_CHK;
      pma_pkg::ST_A_CHK: begin
        if (!sts_i.a_zero)     state_nxt = pma_pkg::ST_B_RD;
        else if (sts_i.i_last) state_nxt = pma_pkg::ST_IDLE;
        else                   state_nxt = pma_pkg::ST_A_RD;
      end
      pma_pkg::ST_B_RD:  state_nxt = pma_pkg::ST_B_CHK;
      pma_pkg::ST_B_CHK, pma_pkg::ST_B_WR: begin
        if (state_r == pma_pkg::ST_B_CHK && !sts_i.b_zero) state_nxt = pma_pkg::ST_B_WR;
        else if (!sts_i.j_last) state_nxt = pma_pkg::ST_B_RD;
        else if (sts_i.i_last)  state_nxt = pma_pkg::ST_IDLE;
        else                    state_nxt = pma_pkg::ST_A_RD;
      end
      pma_pkg::ST_E_RD:  state_nxt = pma_pkg::ST_E_CHK;
      pma_pkg::ST_E_CHK: begin
        state_nxt = sts_i.go_out ? pma_pkg::ST_E_OUT : pma_pkg::ST_E_RD;
      end
      pma_pkg::ST_E_OUT: begin
        if (sts_i.out_free) state_nxt = pma_pkg::ST_IDLE;
      end
      default: state_nxt = pma_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_r)
      pma_pkg::ST_CLR: cmd_o.clr_all = 1'b1;
      pma_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            pma_pkg::ACT_CLEAR, pma_pkg::ACT_COMPUTE: begin
              cmd_o.cur_init = 1'b1;
              cmd_o.restart  = 1'b1;
            end
            pma_pkg::ACT_LOAD_A: cmd_o.load_a    = 1'b1;
            pma_pkg::ACT_LOAD_B: cmd_o.load_b    = 1'b1;
            pma_pkg::ACT_EMIT:   cmd_o.emit_init = 1'b1;
            default: ;
          endcase
        end
      end
      pma_pkg::ST_PCLR: begin
        cmd_o.clr_prod = 1'b1;
        cmd_o.i_init   = sts_i.cur_last;
      end
      pma_pkg::ST_A_RD: cmd_o.a_rd = 1'b1;
      pma_pkg::ST_A_CHK: begin
        cmd_o.j_init = !sts_i.a_zero;
        cmd_o.i_inc  = sts_i.a_zero && !sts_i.i_last;
      end
      pma_pkg::ST_B_RD: cmd_o.b_rd = 1'b1;
      pma_pkg::ST_B_CHK, pma_pkg::ST_B_WR: begin
        if (state_r == pma_pkg::ST_B_CHK && !sts_i.b_zero) begin
          cmd_o.mul = 1'b1;
        end else begin
          cmd_o.p_wr  = (state_r == pma_pkg::ST_B_WR);
          cmd_o.j_inc = !sts_i.j_last;
          cmd_o.i_inc = sts_i.j_last && !sts_i.i_last;
        end
      end
      pma_pkg::ST_E_RD:  cmd_o.e_rd  = 1'b1;
      pma_pkg::ST_E_CHK: cmd_o.e_chk = 1'b1;
      pma_pkg::ST_E_OUT: cmd_o.e_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/pma_dp.sv =====
// Datapath: coefficient stores, loop counters, multiply-accumulate, emit scan and result register.
module pma_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pma_pkg::cmd_t                       cmd_i,
  output pma_pkg::sts_t                       sts_o,
  input  logic signed [pma_pkg::COEF_W-1:0]   in_coef,
  input  logic        [pma_pkg::EXP_W-1:0]    in_exp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pma_pkg::ACC_W-1:0]    out_coef,
  output logic        [pma_pkg::PEXP_W-1:0]   out_exp,
  output logic                                out_list_id,
  output logic                                out_last,
  output logic                                out_all_done
);

  localparam logic [pma_pkg::PEXP_W-1:0] PTOP = pma_pkg::PEXP_W'(pma_pkg::PROD_DEPTH - 1);
  localparam logic [pma_pkg::PEXP_W-1:0] STOP = pma_pkg::PEXP_W'(pma_pkg::MAX_EXP);

  // Stores
  logic signed [pma_pkg::COEF_W-1:0] mem_a [pma_pkg::SRC_DEPTH];
  logic signed [pma_pkg::COEF_W-1:0] mem_b [pma_pkg::SRC_DEPTH];
  logic        [pma_pkg::ACC_W-1:0]  mem_p [pma_pkg::PROD_DEPTH];

  logic signed [pma_pkg::COEF_W-1:0] a_q, b_q;
  logic        [pma_pkg::ACC_W-1:0]  p_q;

  // Control state
  logic [pma_pkg::PEXP_W-1:0]  cur_r;
  logic [pma_pkg::EXP_W-1:0]   i_r, j_r;
  logic [pma_pkg::PHASE_W-1:0] phase_r;
  logic [pma_pkg::PEXP_W-1:0]  cursor_r;
  logic                        seek_next_r;
  logic                        last_r;
  logic                        out_valid_r;

  // Payload
  logic signed [pma_pkg::MUL_W-1:0] mul_r;
  logic [pma_pkg::PEXP_W-1:0]       pa_r;
  logic [pma_pkg::ACC_W-1:0]        hit_coef_r;
  logic [pma_pkg::PEXP_W-1:0]       hit_exp_r;
  logic [pma_pkg::ACC_W-1:0]        out_coef_r;
  logic [pma_pkg::PEXP_W-1:0]       out_exp_r;
  logic                             out_list_r, out_last_r, out_all_r;

  // Memory port selection
  logic                        a_we, b_we, p_we;
  logic [pma_pkg::EXP_W-1:0]   a_waddr, b_waddr, a_raddr, b_raddr;
  logic [pma_pkg::COEF_W-1:0]  a_wdata, b_wdata;
  logic [pma_pkg::PEXP_W-1:0]  p_waddr, p_raddr, ij_sum;
  logic [pma_pkg::ACC_W-1:0]   p_wdata;
  logic                        src_rd, src_clr;
  logic [pma_pkg::ACC_W-1:0]   scan_val;
  logic                        val_nz, cur_zero, go_out, out_free;
  logic [pma_pkg::PEXP_W-1:0]  scan_top, scan_lim;
  logic                        exp_ok;

  assign ij_sum  = {1'b0, i_r} + {1'b0, j_r};
  assign src_rd  = cmd_i.e_rd;
  assign src_clr = cmd_i.clr_all && (cur_r <= STOP);
  assign exp_ok  = ({1'b0, in_exp} <= STOP);

  always_comb begin
    a_we    = (cmd_i.load_a && exp_ok) || src_clr;
    a_waddr = cmd_i.load_a ? in_exp : cur_r[pma_pkg::EXP_W-1:0];
    a_wdata = cmd_i.load_a ? in_coef : '0;
    b_we    = (cmd_i.load_b && exp_ok) || src_clr;
    b_waddr = cmd_i.load_b ? in_exp : cur_r[pma_pkg::EXP_W-1:0];
    b_wdata = cmd_i.load_b ? in_coef : '0;
    a_raddr = src_rd ? cur_r[pma_pkg::EXP_W-1:0] : i_r;
    b_raddr = src_rd ? cur_r[pma_pkg::EXP_W-1:0] : j_r;
    p_we    = cmd_i.clr_all || cmd_i.clr_prod || cmd_i.p_wr;
    p_waddr = cmd_i.p_wr ? pa_r : cur_r;
    p_wdata = cmd_i.p_wr ? (p_q + pma_pkg::ACC_W'(mul_r)) : '0;
    p_raddr = src_rd ? cur_r : ij_sum;
  end

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (cmd_i.a_rd || src_rd) a_q <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    if (cmd_i.b_rd || src_rd) b_q <= mem_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) mem_p[p_waddr] <= p_wdata;
    if (cmd_i.b_rd || src_rd) p_q <= mem_p[p_raddr];
  end

  // Scan value of the current list at the last read exponent
  always_comb begin
    if (phase_r == pma_pkg::PH_SUM) begin
      scan_val = pma_pkg::ACC_W'(a_q) + pma_pkg::ACC_W'(b_q);
    end else begin
      scan_val = p_q;
    end
    val_nz   = (scan_val != '0);
    cur_zero = (cur_r == '0);
    go_out   = cur_zero || (val_nz && seek_next_r);
    out_free = !out_valid_r || !out_stall;
    scan_lim = (phase_r == pma_pkg::PH_SUM) ? STOP : PTOP;
    scan_top = (cursor_r > scan_lim) ? scan_lim : cursor_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      phase_r     <= pma_pkg::PH_PROD;
      cursor_r    <= PTOP;
      seek_next_r <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.cur_init) begin
        cur_r <= '0;
      end else if (cmd_i.clr_all || cmd_i.clr_prod) begin
        cur_r <= (cur_r == PTOP) ? '0 : cur_r + 1'b1;
      end else if (cmd_i.emit_init) begin
        cur_r <= scan_top;
      end else if (cmd_i.e_chk && !go_out) begin
        cur_r <= cur_r - 1'b1;
      end

      if (cmd_i.i_init)      i_r <= '0;
      else if (cmd_i.i_inc)  i_r <= i_r + 1'b1;
      if (cmd_i.j_init)      j_r <= '0;
      else if (cmd_i.j_inc)  j_r <= j_r + 1'b1;

      if (cmd_i.emit_init) begin
        seek_next_r <= 1'b0;
      end else if (cmd_i.e_chk) begin
        seek_next_r <= seek_next_r | val_nz;
        last_r      <= !(val_nz && seek_next_r);
      end

      if (cmd_i.restart) begin
        phase_r  <= pma_pkg::PH_PROD;
        cursor_r <= PTOP;
      end else if (cmd_i.e_out) begin
        if (last_r) begin
          phase_r  <= phase_r + 1'b1;
          cursor_r <= STOP;
        end else begin
          cursor_r <= hit_exp_r - 1'b1;
        end
      end

      if (cmd_i.e_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.b_rd) pa_r <= ij_sum;
    if (cmd_i.mul)  mul_r <= a_q * b_q;
    if (cmd_i.e_chk && !seek_next_r) begin
      hit_coef_r <= scan_val;
      hit_exp_r  <= val_nz ? cur_r : '0;
    end
    if (cmd_i.e_out) begin
      out_coef_r <= hit_coef_r;
      out_exp_r  <= hit_exp_r;
      out_list_r <= phase_r[0];
      out_last_r <= last_r;
      out_all_r  <= last_r && phase_r[0];
    end
  end

  always_comb begin
    sts_o.cur_last   = (cur_r == PTOP);
    sts_o.a_zero     = (a_q == '0);
    sts_o.b_zero     = (b_q == '0);
    sts_o.i_last     = (i_r == pma_pkg::EXP_W'(pma_pkg::MAX_EXP));
    sts_o.j_last     = (j_r == pma_pkg::EXP_W'(pma_pkg::MAX_EXP));
    sts_o.phase_done = phase_r[1];
    sts_o.go_out     = go_out;
    sts_o.out_free   = out_free;
  end

  assign out_valid    = out_valid_r;
  assign out_coef     = out_coef_r;
  assign out_exp      = out_exp_r;
  assign out_list_id  = out_list_r;
  assign out_last     = out_last_r;
  assign out_all_done = out_all_r;

`ifndef NO_ASSERTIONS
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd_i.e_out))
    else $error("result appeared without an emit step");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= PTOP)
    else $error("scan/sweep address beyond product store");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == pma_pkg::PH_PROD || phase_r == pma_pkg::PH_SUM || phase_r == pma_pkg::PH_DONE)
    else $error("emission phase out of range");

  a_no_emit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.e_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");
`endif

endmodule

// ===== hw/rtl/polynomial_multiply_and_add.sv =====
// Emit: scans down past the term and on to the next nonzero one (or exponent 0), then outputs the term.
// Throughput: one item at a time; the single read port of each store sets the scan/loop pace.
// Reset: synchronous, active low; a zeroing pass over the stores then runs before the first item.
// The result register lets the next item enter while a result waits to be taken.
// Top level: polynomial multiply and add with controller and datapath.
module polynomial_multiply_and_add (
  input  logic                                clk,
  input  logic                                rst_n,
  // item input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pma_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [pma_pkg::COEF_W-1:0]   in_coef_in,
  input  logic [pma_pkg::EXP_W-1:0]           in_exp_in,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pma_pkg::ACC_W-1:0]    out_coef_out,
  output logic [pma_pkg::PEXP_W-1:0]          out_exp_out,
  output logic                                out_list_id,
  output logic                                out_last_in_list,
  output logic                                out_all_done
);

  // Commands from the sequencer, status back from the datapath
  pma_pkg::cmd_t cmd;
  pma_pkg::sts_t sts;

  // Sequencer: hold off items while a sweep, the product loop or a scan runs
  pma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall  (in_stall)
  );

  // Stores, multiply-accumulate, scan and the result register
  pma_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_coef      (in_coef_in),
    .in_exp       (in_exp_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_coef     (out_coef_out),
    .out_exp      (out_exp_out),
    .out_list_id  (out_list_id),
    .out_last     (out_last_in_list),
    .out_all_done (out_all_done)
  );

endmodule

// ===== test/polynomial_multiply_and_add_tb.sv =====
// Self-checking testbench for the polynomial multiply and add block.
`timescale 1ns / 1ps

module polynomial_multiply_and_add_tb;
  import pma_pkg::*;

  // Action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int ITEM_TARGET   = 650;  // items that do something, directed part included
  localparam int EMIT_CAP      = 40;   // longest run of emits in one session
  localparam int TAIL_CYCLES   = 8000; // longer than a full emit scan
  localparam int PRINT_LIMIT   = 50;   // mismatch lines printed before going quiet

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [COEF_W-1:0]   coef;
    logic [EXP_W-1:0]    expo;
    bit                  drain;  // hold this item until every expected term has come
  } poly_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]  coef;
    logic [PEXP_W-1:0] expo;
    logic              list;
    logic              last;
    logic              done;
  } poly_term_t;

  typedef enum int {STALL_NONE, STALL_SOME, STALL_MOST} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action = ACT_CLEAR;
  logic [COEF_W-1:0]   in_coef_in = '0;
  logic [EXP_W-1:0]    in_exp_in = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ACC_W-1:0]   out_coef_out;
  logic [PEXP_W-1:0]  out_exp_out;
  logic               out_list_id;
  logic               out_last_in_list;
  logic               out_all_done;

  polynomial_multiply_and_add uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_coef_in       (in_coef_in),
    .in_exp_in        (in_exp_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coef_out     (out_coef_out),
    .out_exp_out      (out_exp_out),
    .out_list_id      (out_list_id),
    .out_last_in_list (out_last_in_list),
    .out_all_done     (out_all_done)
  );

  // ---------------------------------------------------------------------------
  // Predicted block state: both operand stores, the product store and the
  // emission walk (which list, and the highest exponent still to inspect).
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0] first_store  [0:MAX_EXP];
  logic [COEF_W-1:0] second_store [0:MAX_EXP];
  logic [ACC_W-1:0]  product_store[0:PROD_DEPTH-1];
  logic [PHASE_W-1:0] walk_phase;
  int                 walk_cursor;

  poly_item_t pending_items[$];
  poly_term_t expected_terms[$];

  int unsigned issued_items = 0;
  int unsigned taken_items = 0;
  int unsigned terms_seen = 0;
  int unsigned error_count = 0;
  int unsigned gen_count = 0;
  bit          drain_first = 1'b0;

  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  poly_item_t  next_item;
  poly_term_t  want;

  // Zero all three stores and restart the emission.
  task automatic wipe_stores();
    for (int k = 0; k <= MAX_EXP; k++) begin
      first_store[k] = '0;
      second_store[k] = '0;
    end
    for (int k = 0; k < PROD_DEPTH; k++) product_store[k] = '0;
    walk_phase = PH_PROD;
    walk_cursor = 2 * MAX_EXP;
  endtask

  // Coefficient of exponent e in the product list (0) or the live sum list (1).
  function automatic logic [ACC_W-1:0] term_coef(logic lst, int e);
    if (!lst) return product_store[e];
    return {{(ACC_W-COEF_W){first_store[e][COEF_W-1]}}, first_store[e]} +
           {{(ACC_W-COEF_W){second_store[e][COEF_W-1]}}, second_store[e]};
  endfunction

  // Highest exponent at or below top with a nonzero coefficient, -1 if none.
  function automatic int find_term(logic lst, int top);
    for (int e = top; e >= 0; e--)
      if (term_coef(lst, e) != '0) return e;
    return -1;
  endfunction

  task automatic form_product();
    logic signed [MUL_W-1:0] pair;
    for (int k = 0; k < PROD_DEPTH; k++) product_store[k] = '0;
    for (int i = 0; i <= MAX_EXP; i++) begin
      if (first_store[i] == '0) continue;
      for (int j = 0; j <= MAX_EXP; j++) begin
        if (second_store[j] == '0) continue;
        pair = $signed(first_store[i]) * $signed(second_store[j]);
        product_store[i + j] = product_store[i + j] +
                               {{(ACC_W-MUL_W){pair[MUL_W-1]}}, pair};
      end
    end
    walk_phase = PH_PROD;
    walk_cursor = 2 * MAX_EXP;
  endtask

  // Advance the emission by one term and queue what the block must return.
  task automatic emit_next_term();
    poly_term_t t;
    logic       lst;
    int         top;
    int         e;
    int         nxt;
    bit         fin;
    if (walk_phase != PH_PROD && walk_phase != PH_SUM) return;
    lst = (walk_phase == PH_SUM);
    top = lst ? MAX_EXP : 2 * MAX_EXP;
    if (walk_cursor < top) top = walk_cursor;
    t = '0;
    t.list = lst;
    e = find_term(lst, top);
    if (e < 0) begin
      // empty list: a lone 0,0 term closes it
      fin = 1'b1;
    end else begin
      t.coef = term_coef(lst, e);
      t.expo = e[PEXP_W-1:0];
      nxt = (e > 0) ? find_term(lst, e - 1) : -1;
      fin = (nxt < 0);
      if (!fin) walk_cursor = e - 1;
    end
    t.last = fin;
    t.done = fin && lst;
    if (fin) begin
      walk_phase = lst ? PH_DONE : PH_SUM;
      walk_cursor = MAX_EXP;
    end
    expected_terms.push_back(t);
  endtask

  task automatic apply_item(logic [ACTION_W-1:0] act, logic [COEF_W-1:0] coef,
                            logic [EXP_W-1:0] expo);
    case (act)
      ACT_CLEAR:   wipe_stores();
      ACT_LOAD_A:  first_store[expo] = coef;
      ACT_LOAD_B:  second_store[expo] = coef;
      ACT_COMPUTE: form_product();
      ACT_EMIT:    emit_next_term();
      default:     ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] exp_val);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("ERROR @%0t term %0d: %s got %0d, expected %0d", $time, terms_seen, what,
               $signed(got), $signed(exp_val));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [ACTION_W-1:0] act, logic [COEF_W-1:0] coef,
                           logic [EXP_W-1:0] expo);
    pending_items.push_back('{act, coef, expo, drain_first});
    drain_first = 1'b0;
    if (act < ACT_SPARE_LO) gen_count++;
  endtask

  // Lean on the extremes, zero (erases a term) and small values.
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0001;
      4:       return '0;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // Mostly a narrow window so exponents repeat and products collide.
  function automatic logic [EXP_W-1:0] pick_exp();
    case ($urandom_range(0, 9))
      0:       return EXP_W'(MAX_EXP);
      1:       return '0;
      2, 3, 4: return EXP_W'($urandom());
      default: return EXP_W'($urandom_range(0, 15));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and the hard time limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("polynomial_multiply_and_add test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor hook: every item the block accepts updates the model state.
  // Sample at the rising edge, before any output of the block moves.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      apply_item(in_action, in_coef_in, in_exp_in);
      taken_items++;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: feed items from the pending queue in bursts with gaps between them.
  // Change the payload only once the current item has been taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken_items == issued_items)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain && expected_terms.size() != 0)) begin
        next_item = pending_items.pop_front();
        in_action <= next_item.action;
        in_coef_in <= next_item.coef;
        in_exp_in <= next_item.expo;
        in_valid <= 1'b1;
        issued_items++;
        if (burst_left <= 1) begin
          // close the burst; some bursts run straight into the next one
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: switch between free flow, light and heavy stalling.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_SOME: out_stall <= ($urandom_range(0, 2) == 0);
      default:    out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted term with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      terms_seen++;
      if (expected_terms.size() == 0) begin
        report_mismatch("term with nothing expected, coef", out_coef_out, '0);
      end else begin
        want = expected_terms.pop_front();
        if (out_coef_out !== want.coef)
          report_mismatch("coef_out", out_coef_out, want.coef);
        if (out_exp_out !== want.expo)
          report_mismatch("exp_out", ACC_W'(out_exp_out), ACC_W'(want.expo));
        if (out_list_id !== want.list)
          report_mismatch("list_id", ACC_W'(out_list_id), ACC_W'(want.list));
        if (out_last_in_list !== want.last)
          report_mismatch("last_in_list", ACC_W'(out_last_in_list), ACC_W'(want.last));
        if (out_all_done !== want.done)
          report_mismatch("all_done", ACC_W'(out_all_done), ACC_W'(want.done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int              loads_a;
    int              loads_b;
    int              na;
    int              nb;
    int              span;
    int              n_emit;
    logic [COEF_W-1:0] c;
    logic [EXP_W-1:0]  e;

    wipe_stores();

    // Directed: emit on empty stores (both lists give 0,0), emit past the end,
    // an unused code, extreme coefficients at the extreme exponents, an
    // overwrite, a zero load, a product term and a sum term that cancel,
    // a load in the middle of an emission, then a clear after a full drain.
    push_item(ACT_EMIT, 16'h7fff, 10'h3ff);
    push_item(ACT_EMIT, 16'h8000, 10'h000);
    push_item(ACT_EMIT, 16'h5555, 10'h2aa);
    push_item(ACT_SPARE_HI, 16'haaaa, 10'h155);
    push_item(ACT_LOAD_A, 16'h8000, 10'd1023);
    push_item(ACT_LOAD_A, 16'h7fff, 10'd0);
    push_item(ACT_LOAD_A, 16'h0001, 10'd1);
    push_item(ACT_LOAD_A, 16'h0005, 10'd1);
    push_item(ACT_LOAD_B, 16'h8000, 10'd1023);
    push_item(ACT_LOAD_B, 16'hffff, 10'd0);
    push_item(ACT_LOAD_B, 16'hfffb, 10'd1);
    push_item(ACT_LOAD_A, 16'h0000, 10'd512);
    push_item(ACT_COMPUTE, 16'h1234, 10'h0f0);
    repeat (2) push_item(ACT_EMIT, 16'hffff, 10'h3ff);
    push_item(ACT_LOAD_B, 16'h0007, 10'd1022);
    repeat (8) push_item(ACT_EMIT, 16'h0000, 10'h000);
    drain_first = 1'b1;
    push_item(ACT_CLEAR, 16'hffff, 10'h3ff);

    // Random sessions: clear (usually), a handful of loads, compute (usually),
    // then a run of emits with loads and unused codes mixed in now and then.
    loads_a = 0;
    loads_b = 0;
    while (gen_count < ITEM_TARGET) begin
      drain_first = ($urandom_range(0, 4) == 0);
      // bound the term count so compute and emission stay short
      if (loads_a * loads_b > 30 || $urandom_range(0, 9) < 6) begin
        push_item(ACT_CLEAR, pick_coef(), pick_exp());
        loads_a = 0;
        loads_b = 0;
      end
      na = $urandom_range(0, 5);
      nb = $urandom_range(0, 5);
      while (na + nb != 0) begin
        c = pick_coef();
        e = pick_exp();
        if (na != 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
          push_item(ACT_LOAD_A, c, e);
          na--;
          loads_a++;
          if (nb != 0 && $urandom_range(0, 6) == 0) begin
            // cancel this term in the sum list
            push_item(ACT_LOAD_B, COEF_W'(-c), e);
            nb--;
            loads_b++;
          end
        end else begin
          push_item(ACT_LOAD_B, c, e);
          nb--;
          loads_b++;
        end
      end
      if ($urandom_range(0, 19) < 17) push_item(ACT_COMPUTE, pick_coef(), pick_exp());
      span = loads_a * loads_b + loads_a + loads_b + 2;
      if ($urandom_range(0, 3) != 0) n_emit = span + $urandom_range(0, 2);
      else n_emit = $urandom_range(1, span);
      if (n_emit > EMIT_CAP) n_emit = EMIT_CAP;
      repeat (n_emit) begin
        case ($urandom_range(0, 19))
          0: push_item(ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), pick_coef(),
                       pick_exp());
          1: begin
            push_item(ACT_LOAD_A, pick_coef(), pick_exp());
            loads_a++;
          end
          2: begin
            push_item(ACT_LOAD_B, pick_coef(), pick_exp());
            loads_b++;
          end
          default: ;
        endcase
        push_item(ACT_EMIT, pick_coef(), pick_exp());
      end
    end

    // Hold reset low, then release it at a falling edge.
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last item to go in and every expected term to come out,
    // then give the block time to show any stray term.
    while (pending_items.size() != 0 || taken_items != issued_items) @(posedge clk);
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("polynomial_multiply_and_add test passed");
    end else begin
      $display("polynomial_multiply_and_add test failed");
    end
    $finish;
  end

endmodule
